// File: hw/rtl/aip_pkg.sv
`timescale 1ns / 1ps

package aip_pkg;

    // scanner phase
    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SIGNED,
        PH_ZERO,
        PH_AFTERX,
        PH_DIGITS
    } phase_t;

    // radix in use; auto means not decided yet
    typedef enum logic [1:0] {
        RADIX_AUTO,
        RADIX_OCT,
        RADIX_DEC,
        RADIX_HEX
    } radix_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_MORE,
        ST_DONE,
        ST_NODIG,
        ST_EOF
    } status_t;

    // radix_mode register codes, the unused code acts as decimal
    localparam logic [1:0] MODE_DEC  = 2'd0;
    localparam logic [1:0] MODE_HEX  = 2'd1;
    localparam logic [1:0] MODE_AUTO = 2'd2;

    typedef struct packed {
        phase_t      phase;
        logic        minus;
        radix_t      radix;
        logic [15:0] narrow;
        logic [31:0] wide;
    } aip_state_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] narrow;
        logic [31:0] wide;
        logic        minus;
    } aip_result_t;

    localparam aip_state_t STATE_CLEAR = '{
        phase:  PH_SKIP,
        minus:  1'b0,
        radix:  RADIX_DEC,
        narrow: 16'd0,
        wide:   32'd0
    };

endpackage

// File: hw/rtl/aip_step.sv
`timescale 1ns / 1ps

module aip_step
    import aip_pkg::*;
(
    input  logic [7:0]  char_code,
    input  logic        end_of_input,
    input  logic [1:0]  radix_mode,
    input  aip_state_t  state_i,
    output aip_state_t  state_o,
    output aip_result_t result_o
);

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] TEN      = 8'd10;

    // {ok, value} of a digit in the given radix
    function automatic logic [4:0] digit_of(input logic [7:0] c, input radix_t r);
        logic       ok;
        logic [3:0] v;
        ok = 1'b0;
        v  = 4'd0;
        if (c >= CH_0 && c <= CH_9) begin
            ok = 1'b1;
            v  = 4'(c - CH_0);
        end else if (r == RADIX_HEX && c >= CH_LA && c <= CH_LF) begin
            ok = 1'b1;
            v  = 4'(c - CH_LA + TEN);
        end else if (r == RADIX_HEX && c >= CH_UA && c <= CH_UF) begin
            ok = 1'b1;
            v  = 4'(c - CH_UA + TEN);
        end
        if (r == RADIX_OCT && v > 4'd7) begin
            ok = 1'b0;
        end
        return {ok, v};
    endfunction

    // multiply by radix as shift-and-add
    function automatic logic [31:0] scale32(input logic [31:0] x, input radix_t r);
        logic [31:0] y;
        case (r)
            RADIX_OCT: y = x << 3;
            RADIX_HEX: y = x << 4;
            default:   y = (x << 3) + (x << 1);
        endcase
        return y;
    endfunction

    function automatic logic [15:0] scale16(input logic [15:0] x, input radix_t r);
        logic [15:0] y;
        case (r)
            RADIX_OCT: y = x << 3;
            RADIX_HEX: y = x << 4;
            default:   y = (x << 3) + (x << 1);
        endcase
        return y;
    endfunction

    logic        blank;
    logic        first_en;
    radix_t      first_rad;
    radix_t      mode_rad;
    logic        dig_en;
    logic        dig_have;
    radix_t      dig_rad;
    logic [15:0] dig_n;
    logic [31:0] dig_w;
    logic [4:0]  dig;

    assign blank = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);

    always_comb begin
        case (radix_mode)
            MODE_HEX:  mode_rad = RADIX_HEX;
            MODE_AUTO: mode_rad = RADIX_AUTO;
            default:   mode_rad = RADIX_DEC;
        endcase
    end

    always_comb begin
        state_o   = state_i;
        result_o  = '{status: ST_MORE, narrow: 16'd0, wide: 32'd0, minus: 1'b0};
        first_en  = 1'b0;
        first_rad = state_i.radix;
        dig_en    = 1'b0;
        dig_have  = 1'b0;
        dig_rad   = state_i.radix;
        dig_n     = state_i.narrow;
        dig_w     = state_i.wide;
        dig       = 5'd0;

        if (end_of_input) begin
            state_o = STATE_CLEAR;
            if (state_i.phase == PH_DIGITS) begin
                result_o.status = ST_DONE;
                result_o.minus  = state_i.minus;
                result_o.narrow = state_i.minus ? 16'd0 - state_i.narrow : state_i.narrow;
                result_o.wide   = state_i.minus ? 32'd0 - state_i.wide : state_i.wide;
            end else if (state_i.phase == PH_ZERO) begin
                // lone leading zero ends as the value zero
                result_o.status = ST_DONE;
                result_o.minus  = state_i.minus;
            end else begin
                result_o.status = ST_EOF;
            end
        end else begin
            case (state_i.phase)
                PH_SKIP: begin
                    if (!blank) begin
                        state_o.radix = mode_rad;
                        if (char_code == CH_MINUS || char_code == CH_PLUS) begin
                            state_o.minus = (char_code == CH_MINUS);
                            state_o.phase = PH_SIGNED;
                        end else begin
                            first_en  = 1'b1;
                            first_rad = mode_rad;
                        end
                    end
                end
                PH_SIGNED: begin
                    first_en = 1'b1;
                end
                PH_ZERO: begin
                    if (char_code == CH_LX || char_code == CH_UX) begin
                        state_o.radix = RADIX_HEX;
                        state_o.phase = PH_AFTERX;
                    end else begin
                        // leading zero means octal, the zero counts as a digit
                        dig_en   = 1'b1;
                        dig_rad  = RADIX_OCT;
                        dig_have = 1'b1;
                        dig_n    = 16'd0;
                        dig_w    = 32'd0;
                    end
                end
                PH_AFTERX: begin
                    dig_en = 1'b1;
                end
                PH_DIGITS: begin
                    dig_en   = 1'b1;
                    dig_have = 1'b1;
                end
                default: begin
                    state_o = STATE_CLEAR;
                end
            endcase

            if (first_en) begin
                if (first_rad == RADIX_AUTO && char_code == CH_0) begin
                    state_o.phase = PH_ZERO;
                    state_o.radix = RADIX_AUTO;
                end else begin
                    dig_en  = 1'b1;
                    dig_rad = (first_rad == RADIX_AUTO) ? RADIX_DEC : first_rad;
                end
            end

            if (dig_en) begin
                dig = digit_of(char_code, dig_rad);
                if (dig[4]) begin
                    state_o.phase  = PH_DIGITS;
                    state_o.radix  = dig_rad;
                    state_o.narrow = scale16(dig_n, dig_rad) + {12'd0, dig[3:0]};
                    state_o.wide   = scale32(dig_w, dig_rad) + {28'd0, dig[3:0]};
                end else if (dig_have) begin
                    state_o         = STATE_CLEAR;
                    result_o.status = ST_DONE;
                    result_o.minus  = state_i.minus;
                    result_o.narrow = state_i.minus ? 16'd0 - dig_n : dig_n;
                    result_o.wide   = state_i.minus ? 32'd0 - dig_w : dig_w;
                end else begin
                    state_o         = STATE_CLEAR;
                    result_o.status = ST_NODIG;
                end
            end
        end
    end

endmodule

// File: hw/rtl/ascii_integer_parser_unit.sv
`timescale 1ns / 1ps

// character stream integer scanner
// s_ channel: one request per character; s_tdata holds the byte, s_tuser
//   flags end of input (the byte is then ignored)
// m_ channel: exactly one result request per input request, in order;
//   m_tuser is the status (consumed/more, done, no digits, ended early),
//   m_tdata the signed 16-bit and 32-bit values and the minus flag
// on status done or no digits the character was not consumed and must be
//   sent again as the next request
// cfg_wr_en / cfg_wr_data write radix_mode (0 dec, 1 hex, 2 auto); write
//   only while idle, the mode is picked up at the start of the next number
// a request passes from the input register through the result register to m_tvalid
// throughput: one character per cycle unless the receiver stalls, set by
//   the step logic from the input register into scanner state and result register
// reset clears both stages and returns the scanner to skipping whitespace
// when the receiver stalls the result register holds, the input register
//   fills and s_tready drops until m_tready returns

module ascii_integer_parser_unit
    import aip_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,   // radix_mode

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] char_code
    input  logic [0:0]  s_tuser,       // [0] end_of_input

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,       // [15:0] narrow_value, [47:16] wide_value,
                                       // [48] minus_seen, [55:49] zero
    output logic [1:0]  m_tuser        // [1:0] status
);

    logic        in_number_reg;
    logic [1:0]  mode_reg;
    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_eoi_reg;
    logic        out_valid_reg;
    aip_result_t out_result_reg;
    aip_result_t result_next;
    aip_state_t  state_reg;
    aip_state_t  state_next;
    logic        out_free;
    logic        fire;

    // output register can take a new result this cycle
    assign out_free = !out_valid_reg || m_tready;
    // input register moves through the step logic
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // next-state and result for the character in the input register
    aip_step u_step (
        .char_code    (in_char_reg),
        .end_of_input (in_eoi_reg),
        .radix_mode   (mode_reg),
        .state_i      (state_reg),
        .state_o      (state_next),
        .result_o     (result_next)
    );

    // control state and scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_DEC;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= STATE_CLEAR;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= fire;
            end
            if (fire) begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_eoi_reg  <= s_tuser[0];
        end
        if (fire) begin
            out_result_reg <= result_next;
        end
    end

    // marks that the scanner is inside a number, kept for the checks below
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_number_reg <= 1'b0;
        end else if (fire) begin
            in_number_reg <= (state_next.phase != PH_SKIP);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.status;
    assign m_tdata  = {7'd0, out_result_reg.minus, out_result_reg.wide, out_result_reg.narrow};

    // value fields are zero unless the number is done
    a_zero_unless_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_DONE) |-> (m_tdata == 56'd0))
        else $error("result value fields nonzero without done status");

    // a finished result leaves the scanner cleared
    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && result_next.status != ST_MORE) |=>
            (state_reg.phase == PH_SKIP && state_reg.wide == 32'd0 && !state_reg.minus))
        else $error("scanner state not cleared after a final result");

    // both accumulators see the same digits, so the narrow one tracks the wide one
    a_acc_track: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.narrow == state_reg.wide[15:0])
        else $error("narrow accumulator diverged from wide accumulator");

    // back pressure only with a held character
    a_ready_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    // inside-number flag follows the scanner phase
    a_phase_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        in_number_reg == (state_reg.phase != PH_SKIP))
        else $error("number-active flag out of step with scanner phase");

endmodule

// File: bench/ascii_integer_parser_unit_tb.sv
`timescale 1ns / 1ps

module ascii_integer_parser_unit_tb
    import aip_pkg::*;
();

    localparam int CYCLE_LIMIT = 200_000;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE_CYCLES = 10;

    typedef struct {
        logic [7:0] code;
        logic       eoi;
    } char_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_data = 2'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic [0:0]  s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    ascii_integer_parser_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    // characters waiting to be sent, and parse results still owed by the block
    char_req_t   char_backlog[$];
    aip_result_t parse_results_due[$];

    // scanner state as the block should hold it
    logic [1:0]  scan_mode = MODE_DEC;
    phase_t      scan_phase = PH_SKIP;
    logic        scan_minus = 1'b0;
    radix_t      scan_radix = RADIX_DEC;
    logic [15:0] scan_narrow = '0;
    logic [31:0] scan_wide = '0;

    int          error_count = 0;
    int          cycle_count = 0;
    int          queued_count = 0;
    int          send_gap = 0;
    int          recv_stall = 0;
    bit          bursts_on = 1'b1;
    char_req_t   next_req;
    aip_result_t got_result;
    aip_result_t want_result;

    function automatic void clear_scan();
        scan_phase = PH_SKIP;
        scan_minus = 1'b0;
        scan_radix = RADIX_DEC;
        scan_narrow = '0;
        scan_wide = '0;
    endfunction

    // number complete: apply the sign, report, start over
    function automatic aip_result_t finish_number();
        aip_result_t res;
        res.status = ST_DONE;
        res.minus = scan_minus;
        res.narrow = scan_minus ? -scan_narrow : scan_narrow;
        res.wide = scan_minus ? -scan_wide : scan_wide;
        clear_scan();
        return res;
    endfunction

    // one character inside the digit loop, radix already known
    function automatic aip_result_t digit_step(input logic [7:0] ch, input bit have_digits);
        aip_result_t res;
        int base;
        int d;
        res = '0;
        res.status = ST_MORE;
        case (scan_radix)
            RADIX_OCT: base = 8;
            RADIX_HEX: base = 16;
            default:   base = 10;
        endcase
        d = -1;
        if (ch >= "0" && ch <= "9")
            d = ch - "0";
        else if (base == 16 && ch >= "a" && ch <= "f")
            d = ch - "a" + 10;
        else if (base == 16 && ch >= "A" && ch <= "F")
            d = ch - "A" + 10;
        if (d >= base)
            d = -1;
        if (d >= 0) begin
            scan_narrow = 16'(scan_narrow * base + d);
            scan_wide = 32'(scan_wide * base + d);
            scan_phase = PH_DIGITS;
        end else if (have_digits) begin
            res = finish_number();
        end else begin
            clear_scan();
            res.status = ST_NODIG;
        end
        return res;
    endfunction

    // first character after an optional sign; auto radix decides here
    function automatic aip_result_t first_digit(input logic [7:0] ch);
        aip_result_t res;
        res = '0;
        res.status = ST_MORE;
        if (scan_radix == RADIX_AUTO) begin
            if (ch == "0") begin
                scan_phase = PH_ZERO;
                return res;
            end
            scan_radix = RADIX_DEC;
        end
        return digit_step(ch, 1'b0);
    endfunction

    // expected result of one character request, advancing the scanner state
    function automatic aip_result_t scan_char(input logic [7:0] ch, input logic eoi);
        aip_result_t res;
        res = '0;
        res.status = ST_MORE;
        if (eoi) begin
            // a lone leading zero counts as the number zero
            if (scan_phase == PH_DIGITS || scan_phase == PH_ZERO) begin
                res = finish_number();
            end else begin
                clear_scan();
                res.status = ST_EOF;
            end
            return res;
        end
        case (scan_phase)
            PH_SKIP: begin
                if (!(ch == 8'd32 || (ch >= 8'd9 && ch <= 8'd13))) begin
                    // mode is latched at the first non-blank character
                    if (scan_mode == MODE_HEX)
                        scan_radix = RADIX_HEX;
                    else if (scan_mode == MODE_AUTO)
                        scan_radix = RADIX_AUTO;
                    else
                        scan_radix = RADIX_DEC;
                    if (ch == "-" || ch == "+") begin
                        scan_minus = (ch == "-");
                        scan_phase = PH_SIGNED;
                    end else begin
                        res = first_digit(ch);
                    end
                end
            end
            PH_SIGNED: res = first_digit(ch);
            PH_ZERO: begin
                if (ch == "x" || ch == "X") begin
                    scan_radix = RADIX_HEX;
                    scan_phase = PH_AFTERX;
                end else begin
                    scan_radix = RADIX_OCT;
                    res = digit_step(ch, 1'b1);
                end
            end
            PH_AFTERX: res = digit_step(ch, 1'b0);
            PH_DIGITS: res = digit_step(ch, 1'b1);
            default:   clear_scan();
        endcase
        return res;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("error: %s", msg);
    endtask

    task automatic push_item(input logic [7:0] code, input logic eoi);
        char_req_t req;
        req.code = code;
        req.eoi = eoi;
        char_backlog.push_back(req);
        queued_count++;
    endtask

    task automatic push_text(input string text);
        foreach (text[i])
            push_item(text[i], 1'b0);
    endtask

    // end marker with a random byte beside it, the byte must be ignored
    task automatic push_end();
        push_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] blank_char();
        int v;
        v = $urandom_range(8, 13);
        return (v == 8) ? 8'd32 : 8'(v);
    endfunction

    function automatic logic [7:0] digit_char(input int base);
        int v;
        v = $urandom_range(0, base - 1);
        if (v < 10)
            return 8'("0" + v);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
    endfunction

    // one number, mostly well formed with random content, sometimes noise
    task automatic queue_number();
        int kind;
        int base;
        int ndig;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            push_item(8'($urandom_range(0, 255)), 1'b0);
            return;
        end
        if (kind == 1) begin
            push_end();
            return;
        end
        repeat ($urandom_range(0, 2))
            push_item(blank_char(), 1'b0);
        case ($urandom_range(0, 5))
            0, 1: push_item("-", 1'b0);
            2:    push_item("+", 1'b0);
            default: ;
        endcase
        base = (scan_mode == MODE_HEX) ? 16 : 10;
        if (scan_mode == MODE_AUTO) begin
            case ($urandom_range(0, 2))
                0: begin
                    push_item("0", 1'b0);
                    push_item($urandom_range(0, 1) ? "x" : "X", 1'b0);
                    base = 16;
                end
                1: begin
                    push_item("0", 1'b0);
                    base = 8;
                end
                default: ;
            endcase
        end
        // long runs wrap narrow, at times wide too; zero digits gives a broken number
        ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
        repeat (ndig)
            push_item(digit_char(base), 1'b0);
        case ($urandom_range(0, 4))
            0: push_end();
            1: push_item(8'($urandom_range(0, 255)), 1'b0);
            2: push_item(",", 1'b0);
            default: push_item(blank_char(), 1'b0);
        endcase
    endtask

    // wait until every request went out and every result came back
    task automatic wait_idle();
        while (char_backlog.size() != 0 || s_tvalid || parse_results_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_mode(input logic [1:0] mode);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        scan_mode = mode;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // request driver: holds tdata/tuser until taken, random gaps between requests
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                parse_results_due.push_back(scan_char(s_tdata, s_tuser[0]));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (char_backlog.size() != 0) begin
                    next_req = char_backlog.pop_front();
                    s_tdata <= next_req.code;
                    s_tuser <= next_req.eoi;
                    s_tvalid <= 1'b1;
                    if (bursts_on && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 10);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compares each result with the oldest one owed, random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_result.status = status_t'(m_tuser);
                got_result.narrow = m_tdata[15:0];
                got_result.wide = m_tdata[47:16];
                got_result.minus = m_tdata[48];
                if (parse_results_due.size() == 0) begin
                    flag_error($sformatf("unexpected result status %0d", got_result.status));
                end else begin
                    want_result = parse_results_due.pop_front();
                    if (got_result.status !== want_result.status
                            || got_result.narrow !== want_result.narrow
                            || got_result.wide !== want_result.wide
                            || got_result.minus !== want_result.minus)
                        flag_error($sformatf(
                            "expected st %0d n %0d w %0d m %0d, got st %0d n %0d w %0d m %0d",
                            want_result.status, $signed(want_result.narrow),
                            $signed(want_result.wide), want_result.minus,
                            got_result.status, $signed(got_result.narrow),
                            $signed(got_result.wide), got_result.minus));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else if (bursts_on && $urandom_range(0, 7) == 0) begin
                recv_stall = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [1:0] mode_plan[6];
        mode_plan = '{MODE_AUTO, MODE_DEC, MODE_HEX, 2'd3, MODE_AUTO, MODE_HEX};
        clear_scan();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // decimal after reset: sign and done, end after sign, top byte, sign with no digits
        push_text(" -12+");
        push_item("-", 1'b0);
        push_end();
        push_item(8'hFF, 1'b0);
        push_text("+,");

        // hex: mixed case digits, zero byte, then a number left open
        write_mode(MODE_HEX);
        push_text("Ff0g");
        push_item(8'h00, 1'b0);
        push_text("-A");

        // switching mode mid-number keeps hex for the open number, then code 3 acts decimal
        write_mode(2'd3);
        push_text("b 19a");

        // auto: end right after 0x, 0x with a non-hex character, lone zero, octal
        write_mode(MODE_AUTO);
        push_text("0x");
        push_end();
        push_text("0xg");
        push_item("0", 1'b0);
        push_end();
        push_text("017 ");

        foreach (mode_plan[p]) begin
            write_mode(mode_plan[p]);
            if (p == 5)
                bursts_on = 1'b0;
            queued_count = 0;
            while (queued_count < 118)
                queue_number();
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (parse_results_due.size() != 0)
            flag_error($sformatf("%0d results never arrived", parse_results_due.size()));
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/aip_pkg.sv
hw/rtl/aip_step.sv
hw/rtl/ascii_integer_parser_unit.sv
bench/ascii_integer_parser_unit_tb.sv
